### hw/rtl/psb_pkg.sv
// ----------------------------------------------------------------------------
// psb_pkg
// Shared types and constants for the palette sprite blitter.
// ----------------------------------------------------------------------------
package psb_pkg;

  // Screen and sprite geometry
  localparam int SCREEN_WIDTH    = 320;
  localparam int SCREEN_HEIGHT   = 240;
  localparam int MAX_SPRITE_SIZE = 64;

  // Field widths
  localparam int COORD_W   = 12;                        // origin / camera registers
  localparam int SIZE_W    = 7;                         // sprite width / height registers
  localparam int CLIP_W    = 8;                         // clip height register
  localparam int INDEX_W   = 8;                         // palette index
  localparam int RGB_W     = 24;
  localparam int COLOR_W   = 32;
  localparam int ADDR_W    = 17;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = COORD_W;

  localparam int PAL_DEPTH = 256;

  // Derived widths
  localparam int CNT_W = $clog2(MAX_SPRITE_SIZE);       // column / row counters
  localparam int CMP_W = SIZE_W + CNT_W + 1;            // counter vs. size compare
  localparam int POS_W = COORD_W + 2;                   // screen position, signed
  localparam int ROW_W = $clog2(SCREEN_HEIGHT);
  localparam int COL_W = $clog2(SCREEN_WIDTH);

  localparam logic [COLOR_W-RGB_W-1:0] ALPHA_OPAQUE = 8'hFF;

  // Result queue
  localparam int OUT_DEPTH = 3;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  // Request types
  localparam logic REQ_PALETTE = 1'b0;
  localparam logic REQ_PIXEL   = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_X      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_Y      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_HEIGHT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_HEIGHT   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_INDEX     = 3'd7;

  // One result item
  typedef struct packed {
    logic               write_enable;
    logic [ADDR_W-1:0]  write_address;
    logic [COLOR_W-1:0] write_color;
    logic               sprite_done;
  } psb_result_t;

endpackage

### hw/rtl/palette_sprite_blitter.sv
// ----------------------------------------------------------------------------
// palette_sprite_blitter
// Palette-indexed sprite blitter with color key and screen clipping.
// ----------------------------------------------------------------------------
// The block takes one item per clock while in_stall is low: either a palette
// load (req_type 0), which writes a 24-bit RGB entry into a 256-entry palette
// memory, or a sprite pixel (req_type 1) given as a palette index in raster
// order. Every item gives exactly one result, through the first stage and the
// result queue. A pixel inside the screen width and the visible rows whose
// index differs from key_index gives a write with the framebuffer address
// (row * 320 + column) and the ARGB color (alpha 0xFF); any other item gives
// a result with write_enable, write_address and write_color zero. sprite_done
// marks the last pixel of the sprite and returns the column and row counters
// to zero. The first stage does the position math and a registered palette
// read; a three-entry result queue follows, and in_stall rises only when the
// queue entries plus the stage in flight reach the queue depth, so the sustained
// rate is one item per cycle while out_stall is low, and in_stall never follows
// out_stall within the same cycle. Load the palette before any pixel uses an
// entry. The configuration port is always ready; write it only while idle.
// ----------------------------------------------------------------------------
module palette_sprite_blitter
  import psb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  req_type,
  input  logic [INDEX_W-1:0]    pal_index,
  input  logic [RGB_W-1:0]      pal_rgb,
  input  logic [INDEX_W-1:0]    pixel,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  write_enable,
  output logic [ADDR_W-1:0]     write_address,
  output logic [COLOR_W-1:0]    write_color,
  output logic                  sprite_done,
  // configuration channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers
  logic [COORD_W-1:0] origin_x;
  logic [COORD_W-1:0] origin_y;
  logic [COORD_W-1:0] camera_x;
  logic [COORD_W-1:0] camera_y;
  logic [SIZE_W-1:0]  sprite_width;
  logic [SIZE_W-1:0]  sprite_height;
  logic [CLIP_W-1:0]  clip_height;
  logic [INDEX_W-1:0] key_index;

  // Raster counters
  logic [CNT_W-1:0]   column_count;
  logic [CNT_W-1:0]   row_count;

  // Palette memory, undefined until loaded
  logic [RGB_W-1:0]   palette_table [PAL_DEPTH];

  // First stage
  logic               p_valid;
  logic               p_we;
  logic [ADDR_W-1:0]  p_addr;
  logic               p_done;
  logic [RGB_W-1:0]   p_rgb;

  // Handshake
  logic               in_accept;
  logic               is_pixel;
  logic [OUT_CNT_W-1:0] q_count;
  logic [OUT_CNT_W:0]   occupancy;

  // Position math
  logic [CMP_W-1:0]   w_lim;
  logic [CMP_W-1:0]   h_lim;
  logic [CMP_W-1:0]   col_inc;
  logic [CMP_W-1:0]   row_inc;
  logic               last_col;
  logic               done;
  logic [POS_W-1:0]   dx;
  logic [POS_W-1:0]   dy;
  logic [POS_W-1:0]   vis;
  logic               show;
  logic [ADDR_W-1:0]  addr;

  psb_result_t        p_result;
  psb_result_t        q_head;

  // --------------------------------------------------------------------------
  // Handshake: stall once the stage and queue together could overflow
  // --------------------------------------------------------------------------
  assign occupancy = {1'b0, q_count} + (OUT_CNT_W + 1)'(p_valid);
  assign in_stall  = (occupancy >= (OUT_CNT_W + 1)'(OUT_DEPTH));
  assign in_accept = in_valid && !in_stall;
  assign is_pixel  = (req_type == REQ_PIXEL);
  assign cfg_ready = 1'b1;

  // --------------------------------------------------------------------------
  // Configuration writes
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x      <= '0;
      origin_y      <= '0;
      camera_x      <= '0;
      camera_y      <= '0;
      sprite_width  <= SIZE_W'(1);
      sprite_height <= SIZE_W'(1);
      clip_height   <= CLIP_W'(SCREEN_HEIGHT);
      key_index     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ORIGIN_X:      origin_x      <= cfg_data[COORD_W-1:0];
        CFG_ORIGIN_Y:      origin_y      <= cfg_data[COORD_W-1:0];
        CFG_CAMERA_X:      camera_x      <= cfg_data[COORD_W-1:0];
        CFG_CAMERA_Y:      camera_y      <= cfg_data[COORD_W-1:0];
        CFG_SPRITE_WIDTH:  sprite_width  <= cfg_data[SIZE_W-1:0];
        CFG_SPRITE_HEIGHT: sprite_height <= cfg_data[SIZE_W-1:0];
        CFG_CLIP_HEIGHT:   clip_height   <= cfg_data[CLIP_W-1:0];
        CFG_KEY_INDEX:     key_index     <= cfg_data[INDEX_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Placement and clipping for the incoming pixel
  // --------------------------------------------------------------------------
  always_comb begin
    // Zero size counts as one; oversize clamps to the maximum sprite size
    if (sprite_width == '0) begin
      w_lim = CMP_W'(1);
    end else if (CMP_W'(sprite_width) > CMP_W'(MAX_SPRITE_SIZE)) begin
      w_lim = CMP_W'(MAX_SPRITE_SIZE);
    end else begin
      w_lim = CMP_W'(sprite_width);
    end
    if (sprite_height == '0) begin
      h_lim = CMP_W'(1);
    end else if (CMP_W'(sprite_height) > CMP_W'(MAX_SPRITE_SIZE)) begin
      h_lim = CMP_W'(MAX_SPRITE_SIZE);
    end else begin
      h_lim = CMP_W'(sprite_height);
    end

    // At or past the last column (row) wraps, also after a size change
    col_inc  = CMP_W'(column_count) + CMP_W'(1);
    row_inc  = CMP_W'(row_count) + CMP_W'(1);
    last_col = (col_inc >= w_lim);
    done     = last_col && (row_inc >= h_lim);

    // Screen position, two's complement
    dx = {{(POS_W-COORD_W){origin_x[COORD_W-1]}}, origin_x}
       - {{(POS_W-COORD_W){camera_x[COORD_W-1]}}, camera_x}
       + POS_W'(column_count);
    dy = {{(POS_W-COORD_W){origin_y[COORD_W-1]}}, origin_y}
       - {{(POS_W-COORD_W){camera_y[COORD_W-1]}}, camera_y}
       + POS_W'(row_count);

    // Visible rows never exceed the screen height
    if (POS_W'(clip_height) > POS_W'(SCREEN_HEIGHT)) begin
      vis = POS_W'(SCREEN_HEIGHT);
    end else begin
      vis = POS_W'(clip_height);
    end

    // Sign bit clear means non-negative; then the unsigned compares hold
    show = !dx[POS_W-1] && (dx < POS_W'(SCREEN_WIDTH))
        && !dy[POS_W-1] && (dy < vis)
        && (pixel != key_index);

    addr = ADDR_W'(dy[ROW_W-1:0]) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(dx[COL_W-1:0]);
  end

  // --------------------------------------------------------------------------
  // Raster counters: advance on every accepted pixel
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (in_accept && is_pixel) begin
      if (done) begin
        column_count <= '0;
        row_count    <= '0;
      end else if (last_col) begin
        column_count <= '0;
        row_count    <= row_count + 1'b1;
      end else begin
        column_count <= column_count + 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Palette memory: load on palette items, registered read on pixels
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_accept && !is_pixel) begin
      palette_table[pal_index] <= pal_rgb;
    end
    if (in_accept && is_pixel) begin
      p_rgb <= palette_table[pixel];
    end
  end

  // --------------------------------------------------------------------------
  // First stage: hold the write decision next to the palette read
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      p_we   <= is_pixel && show;
      p_addr <= (is_pixel && show) ? addr : '0;
      p_done <= is_pixel && done;
    end
  end

  // Zero the color on dropped pixels and palette loads
  always_comb begin
    p_result.write_enable  = p_we;
    p_result.write_address = p_addr;
    p_result.write_color   = p_we ? {ALPHA_OPAQUE, p_rgb} : '0;
    p_result.sprite_done   = p_done;
  end

  // --------------------------------------------------------------------------
  // Result queue: the stage always drains into it; in_stall keeps room
  // --------------------------------------------------------------------------
  psb_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (p_valid),
    .push_data (p_result),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (q_head),
    .count     (q_count)
  );

  assign write_enable  = q_head.write_enable;
  assign write_address = q_head.write_address;
  assign write_color   = q_head.write_color;
  assign sprite_done   = q_head.sprite_done;

endmodule

### hw/rtl/psb_out_fifo.sv
// ----------------------------------------------------------------------------
// psb_out_fifo
// Small result queue in flip-flops that decouples the blitter pipeline from
// a stalling consumer.
// ----------------------------------------------------------------------------
module psb_out_fifo
  import psb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  psb_result_t          push_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output psb_result_t          head,
  output logic [OUT_CNT_W-1:0] count
);

  psb_result_t            entries [OUT_DEPTH];
  logic [OUT_PTR_W-1:0]   wr_ptr;
  logic [OUT_PTR_W-1:0]   rd_ptr;
  logic                   pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && !out_stall;
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + OUT_CNT_W'(push) - OUT_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule
